/* sv/ses_pkg.sv */
// Package for the sensor event statistics block: operation codes, result layout,
// saturation limits and the saturating counter helper. No dependencies.
package ses_pkg;

   // event kinds carried in the input tuser
   typedef enum logic [2:0] {
      OP_TEMP       = 3'd0,
      OP_HUM        = 3'd1,
      OP_VALID      = 3'd2,
      OP_EXCEED     = 3'd3,
      OP_DISCONNECT = 3'd4,
      OP_ERROR      = 3'd5,
      OP_OVERFLOW   = 3'd6,
      OP_IGNORE     = 3'd7
   } op_type;

   localparam int REQ_USER_W = 3;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 184;

   localparam logic [31:0]        CNT_MAX   = 32'hFFFF_FFFF;
   localparam logic signed [47:0] SUM_MAX   = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] SUM_MIN   = 48'sh8000_0000_0000;
   localparam logic signed [15:0] LOW_INIT  = 16'sh7FFF;
   localparam logic signed [15:0] HIGH_INIT = 16'sh8000;

   // result item, last field in the lowest bits
   typedef struct packed {
      logic [2:0]         pad;
      logic               worst_known;
      logic [31:0]        worst_errors;
      logic [3:0]         worst_sensor;
      logic [31:0]        sensor_errors;
      logic signed [47:0] channel_sum;
      logic signed [15:0] channel_max;
      logic signed [15:0] channel_min;
      logic [31:0]        event_total;
   } rsp_type;

   // counter increment that sticks at all ones
   function automatic logic [31:0] bump(input logic [31:0] c);
      return (c == CNT_MAX) ? c : c + 32'd1;
   endfunction

endpackage

/* sv/ses_err_table.sv */
// Per-sensor error count table for the sensor event statistics block.
// Registered read with bypass of a same-cycle write; valid bits make reset instant.
// Depends on nothing outside this file.
module ses_err_table #(
   parameter int SLOTS  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data,
   output logic [31:0]       rd_data
);

   logic [31:0]      mem [SLOTS];
   logic [31:0]      mem_rd_ff;
   logic [SLOTS-1:0] live_ff;
   logic             live_rd_ff;
   logic             fwd_ff;
   logic [31:0]      fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else if (wr_en) begin
         live_ff[wr_addr] <= 1'b1;
      end
   end

   // hold bypass and entry validity alongside the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         live_rd_ff  <= live_ff[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : (live_rd_ff ? mem_rd_ff : 32'd0);

endmodule

/* sv/sensor_event_statistics.sv */
// Sensor event statistics: top level with input stage, update logic and result register.
// Depends on ses_pkg and ses_err_table.
//
// Usage:
//  Input channel (req_): one event per item. req_tuser holds the operation
//  (temperature sample, humidity sample, valid, exceed, disconnect, error,
//  overflow, ignored); req_tdata holds the signed sample in hundredths and
//  the signed sensor id of a failing sensor.
//  Result channel (rsp_): exactly one item per event, in order, carrying the
//  updated count of the touched category, the running min/max/sum of the
//  sampled channel, the named sensor's error count and the current leader.
//  An accepted item passes the input register, then the result register, to rsp_.
//  Throughput: one item per cycle while rsp_ is not stalled; every update is
//  one pass of short logic between the input register and the result register,
//  with the per-sensor table read on acceptance, written when the item is processed.
//  Stall: while rsp_tready is low the result register holds and the input
//  register still takes one more item, then req_tready drops.
//  Reset: clears all counters, sums and the leader, sets min/max to their
//  extreme starting values and marks every table entry as zero at once.
module sensor_event_statistics #(
   parameter int SENSOR_SLOTS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [15:0] sample_value, [23:16] sensor_id
   input  logic [ses_pkg::REQ_DATA_W-1:0] req_tdata,
   // [2:0] operation
   input  logic [ses_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [31:0] event_total, [47:32] channel_min, [63:48] channel_max,
   // [111:64] channel_sum, [143:112] sensor_errors, [147:144] worst_sensor,
   // [179:148] worst_errors, [180] worst_known, [183:181] zero
   output logic [ses_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import ses_pkg::*;

   localparam int SLOT_W = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;

   // input stage
   logic               in_valid_ff, in_valid_in;
   op_type             in_op_ff;
   logic signed [15:0] in_sample_ff;
   logic signed [7:0]  in_id_ff;

   // running state
   logic [31:0]        valid_total_ff, valid_total_in;
   logic [31:0]        error_total_ff, error_total_in;
   logic [31:0]        exceed_total_ff, exceed_total_in;
   logic [31:0]        overflow_total_ff, overflow_total_in;
   logic [31:0]        disconnect_total_ff, disconnect_total_in;
   logic signed [15:0] temp_low_ff, temp_low_in, temp_high_ff, temp_high_in;
   logic signed [47:0] temp_acc_ff, temp_acc_in;
   logic [31:0]        temp_samples_ff, temp_samples_in;
   logic signed [15:0] hum_low_ff, hum_low_in, hum_high_ff, hum_high_in;
   logic signed [47:0] hum_acc_ff, hum_acc_in;
   logic [31:0]        hum_samples_ff, hum_samples_in;
   logic [SLOT_W-1:0]  leader_id_ff, leader_id_in;
   logic [31:0]        leader_count_ff, leader_count_in;
   logic               leader_valid_ff, leader_valid_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               advance;
   logic               req_accept;
   logic               id_in_range;
   logic               slot_wr_en;
   logic [31:0]        slot_old;
   logic [31:0]        slot_new;

   // selected channel and its update
   logic               is_hum;
   logic signed [15:0] ch_low, ch_high, new_low, new_high;
   logic signed [47:0] ch_acc, new_acc;
   logic [31:0]        ch_samples, new_samples;
   logic [48:0]        sum_wide;

   // advance when the result register is empty or being drained
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign in_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // start the operation register at a known code so the decoder never sees X
   always_ff @(posedge clock) begin
      if (reset) begin
         in_op_ff <= OP_IGNORE;
      end else if (req_accept) begin
         in_op_ff     <= op_type'(req_tuser);
         in_sample_ff <= req_tdata[15:0];
         in_id_ff     <= req_tdata[23:16];
      end
   end

   // ids below zero or past the last slot are not tallied per sensor
   assign id_in_range = !in_id_ff[7] && ({1'b0, in_id_ff} < 9'(SENSOR_SLOTS));
   assign slot_new    = bump(slot_old);
   assign slot_wr_en  = advance && (in_op_ff == OP_ERROR) && id_in_range;

   ses_err_table #(
      .SLOTS  (SENSOR_SLOTS),
      .ADDR_W (SLOT_W)
   ) u_err_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (req_tdata[16 +: SLOT_W]),
      .wr_en   (slot_wr_en),
      .wr_addr (in_id_ff[SLOT_W-1:0]),
      .wr_data (slot_new),
      .rd_data (slot_old)
   );

   // channel update: min, max, saturating sum, saturating count
   assign is_hum     = (in_op_ff == OP_HUM);
   assign ch_low     = is_hum ? hum_low_ff     : temp_low_ff;
   assign ch_high    = is_hum ? hum_high_ff    : temp_high_ff;
   assign ch_acc     = is_hum ? hum_acc_ff     : temp_acc_ff;
   assign ch_samples = is_hum ? hum_samples_ff : temp_samples_ff;

   assign new_low     = (in_sample_ff < ch_low)  ? in_sample_ff : ch_low;
   assign new_high    = (in_sample_ff > ch_high) ? in_sample_ff : ch_high;
   assign sum_wide    = {ch_acc[47], ch_acc} + {{33{in_sample_ff[15]}}, in_sample_ff};
   assign new_samples = bump(ch_samples);

   // clamp when the two top bits of the wide sum disagree
   always_comb begin
      if (sum_wide[48] != sum_wide[47]) begin
         new_acc = sum_wide[48] ? SUM_MIN : SUM_MAX;
      end else begin
         new_acc = sum_wide[47:0];
      end
   end

   always_comb begin
      valid_total_in      = valid_total_ff;
      error_total_in      = error_total_ff;
      exceed_total_in     = exceed_total_ff;
      overflow_total_in   = overflow_total_ff;
      disconnect_total_in = disconnect_total_ff;
      temp_low_in         = temp_low_ff;
      temp_high_in        = temp_high_ff;
      temp_acc_in         = temp_acc_ff;
      temp_samples_in     = temp_samples_ff;
      hum_low_in          = hum_low_ff;
      hum_high_in         = hum_high_ff;
      hum_acc_in          = hum_acc_ff;
      hum_samples_in      = hum_samples_ff;
      leader_id_in        = leader_id_ff;
      leader_count_in     = leader_count_ff;
      leader_valid_in     = leader_valid_ff;
      rsp_data_in         = '0;
      unique case (in_op_ff)
         OP_TEMP: begin
            temp_low_in     = new_low;
            temp_high_in    = new_high;
            temp_acc_in     = new_acc;
            temp_samples_in = new_samples;
         end
         OP_HUM: begin
            hum_low_in     = new_low;
            hum_high_in    = new_high;
            hum_acc_in     = new_acc;
            hum_samples_in = new_samples;
         end
         OP_VALID: begin
            valid_total_in          = bump(valid_total_ff);
            rsp_data_in.event_total = valid_total_in;
         end
         OP_EXCEED: begin
            exceed_total_in         = bump(exceed_total_ff);
            rsp_data_in.event_total = exceed_total_in;
         end
         OP_DISCONNECT: begin
            disconnect_total_in     = bump(disconnect_total_ff);
            rsp_data_in.event_total = disconnect_total_in;
         end
         OP_ERROR: begin
            error_total_in          = bump(error_total_ff);
            rsp_data_in.event_total = error_total_in;
            if (id_in_range) begin
               rsp_data_in.sensor_errors = slot_new;
               // strictly greater: on a tie the earlier leader stays
               if (slot_new > leader_count_ff) begin
                  leader_count_in = slot_new;
                  leader_id_in    = in_id_ff[SLOT_W-1:0];
                  leader_valid_in = 1'b1;
               end
            end
         end
         OP_OVERFLOW: begin
            overflow_total_in       = bump(overflow_total_ff);
            rsp_data_in.event_total = overflow_total_in;
         end
         OP_IGNORE: begin
         end
      endcase
      if (in_op_ff == OP_TEMP || in_op_ff == OP_HUM) begin
         rsp_data_in.event_total = new_samples;
         rsp_data_in.channel_min = new_low;
         rsp_data_in.channel_max = new_high;
         rsp_data_in.channel_sum = new_acc;
      end
      rsp_data_in.worst_sensor = 4'(leader_id_in);
      rsp_data_in.worst_errors = leader_count_in;
      rsp_data_in.worst_known  = leader_valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_total_ff      <= '0;
         error_total_ff      <= '0;
         exceed_total_ff     <= '0;
         overflow_total_ff   <= '0;
         disconnect_total_ff <= '0;
         temp_low_ff         <= LOW_INIT;
         temp_high_ff        <= HIGH_INIT;
         temp_acc_ff         <= '0;
         temp_samples_ff     <= '0;
         hum_low_ff          <= LOW_INIT;
         hum_high_ff         <= HIGH_INIT;
         hum_acc_ff          <= '0;
         hum_samples_ff      <= '0;
         leader_id_ff        <= '0;
         leader_count_ff     <= '0;
         leader_valid_ff     <= 1'b0;
      end else if (advance) begin
         valid_total_ff      <= valid_total_in;
         error_total_ff      <= error_total_in;
         exceed_total_ff     <= exceed_total_in;
         overflow_total_ff   <= overflow_total_in;
         disconnect_total_ff <= disconnect_total_in;
         temp_low_ff         <= temp_low_in;
         temp_high_ff        <= temp_high_in;
         temp_acc_ff         <= temp_acc_in;
         temp_samples_ff     <= temp_samples_in;
         hum_low_ff          <= hum_low_in;
         hum_high_ff         <= hum_high_in;
         hum_acc_ff          <= hum_acc_in;
         hum_samples_ff      <= hum_samples_in;
         leader_id_ff        <= leader_id_in;
         leader_count_ff     <= leader_count_in;
         leader_valid_ff     <= leader_valid_in;
      end
   end

   // result register: load on advance, drop once taken
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* sv/ses_checker.sv */
// Port-level checker for the sensor event statistics block, bound to the top level.
// Depends on ses_pkg for the result layout.
module ses_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [ses_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import ses_pkg::*;

   rsp_type rsp;
   assign rsp = rsp_type'(rsp_tdata);

   // no result straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // running min never above running max (both zero off samples)
   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.channel_min <= rsp.channel_max)
      else $error("channel min above max");

   // leader fields stay zero until the first tallied error
   a_leader_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.worst_known |-> rsp.worst_errors == 32'd0
                                        && rsp.worst_sensor == 4'd0)
      else $error("leader shown before any tallied error");

   // a known leader has at least one error
   a_leader_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.worst_known |-> rsp.worst_errors != 32'd0)
      else $error("known leader with zero errors");

endmodule

bind sensor_event_statistics ses_checker u_ses_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
